// ----- src/hdrc_pkg.sv -----
package hdrc_pkg;

	// Operation codes carried by an item.
	typedef enum logic [1:0] {
		FUNC_LOOKUP       = 2'd0,
		FUNC_INSERT       = 2'd1,
		FUNC_INVALIDATE   = 2'd2,
		FUNC_CLEAR_COUNTS = 2'd3
	} func_t;

	// Status codes; anything above STATUS_IMPOSSIBLE is not cached.
	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_IMPOSSIBLE = 2'd1;

	localparam int BOARD_BITS        = 64;
	localparam int KEY_BITS          = 48;
	localparam int CNT_BITS          = 32;
	localparam int PORT_PAYLOAD_BITS = 32;
	localparam int CFG_BITS          = 4;
	localparam int MIN_INDEX_BITS    = 8;

	localparam logic [CFG_BITS-1:0] INDEX_BITS_RESET = 4'd12;

	// Finalizer constants.
	localparam logic [63:0] MIX_ADD  = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL2 = 64'h94d049bb133111eb;
	localparam int MIX_SH1 = 30;
	localparam int MIX_SH2 = 27;
	localparam int MIX_SH3 = 31;

	// Queue between the hash front and the memory back.
	localparam int QDEPTH    = 8;
	localparam int QPTR_BITS = 3;
	localparam int QCNT_BITS = 4;

	typedef struct packed {
		func_t                         func;
		logic [BOARD_BITS-1:0]         board;
		logic [KEY_BITS-1:0]           key;
		logic [1:0]                    status;
		logic [PORT_PAYLOAD_BITS-1:0]  payload;
	} op_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_stat_t;

endpackage

// ----- src/hdrc_hash.sv -----
module hdrc_hash #(
	parameter int DEPTH_LOG2 = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  hdrc_pkg::op_t                 in_op,
	input  logic [hdrc_pkg::CFG_BITS-1:0] index_bits,
	output logic                          out_valid,
	output hdrc_pkg::op_t                 out_op,
	output logic [DEPTH_LOG2-1:0]         out_idx
);
	import hdrc_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	op_t         op_s1, op_s2, op_s3, op_s4, op_s5;
	logic [63:0] x_d, h0_d, y_d, h_d, f_d;
	logic [63:0] x_s1, z_s3;
	logic [63:0] ll_s2, ll_s4;
	logic [31:0] hl_s2, lh_s2, hl_s4, lh_s4;
	logic [DEPTH_LOG2-1:0] mask_d, idx_s5;

	// Stage 1: add, xor and first shift-xor.
	assign h0_d = in_op.board ^ (64'(in_op.key) + MIX_ADD);
	assign x_d  = h0_d ^ (h0_d >> MIX_SH1);

	// Stage 3: recombine the partial products of the first multiply.
	assign y_d = ll_s2 + {hl_s2 + lh_s2, 32'b0};

	// Stage 5: recombine the second multiply and fold down to an index.
	assign h_d = ll_s4 + {hl_s4 + lh_s4, 32'b0};
	assign f_d = h_d ^ (h_d >> MIX_SH3);

	always_comb begin
		for (int i = 0; i < DEPTH_LOG2; i++) begin
			mask_d[i] = (i < MIN_INDEX_BITS) || (i < int'(index_bits));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= in_op;
		x_s1  <= x_d;

		op_s2 <= op_s1;
		ll_s2 <= 64'(x_s1[31:0]) * 64'(MIX_MUL1[31:0]);
		hl_s2 <= x_s1[63:32] * MIX_MUL1[31:0];
		lh_s2 <= x_s1[31:0] * MIX_MUL1[63:32];

		op_s3 <= op_s2;
		z_s3  <= y_d ^ (y_d >> MIX_SH2);

		op_s4 <= op_s3;
		ll_s4 <= 64'(z_s3[31:0]) * 64'(MIX_MUL2[31:0]);
		hl_s4 <= z_s3[63:32] * MIX_MUL2[31:0];
		lh_s4 <= z_s3[31:0] * MIX_MUL2[63:32];

		op_s5  <= op_s4;
		idx_s5 <= f_d[DEPTH_LOG2-1:0] & mask_d;
	end

	assign out_valid = v_s5;
	assign out_op    = op_s5;
	assign out_idx   = idx_s5;

endmodule

// ----- src/hdrc_queue.sv -----
module hdrc_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] head_data
);
	import hdrc_pkg::*;

	logic [W-1:0]           mem_q [QDEPTH];
	logic [QPTR_BITS-1:0]   head_q, tail_q;
	logic [QCNT_BITS-1:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_q + QPTR_BITS'(1);
			end
			if (pop) begin
				head_q <= head_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_BITS'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_BITS'(1);
			end
		end
	end

	assign not_empty = (cnt_q != '0);
	assign head_data = mem_q[head_q];

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != QCNT_BITS'(QDEPTH)))
		else $error("queue pushed while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != '0))
		else $error("queue popped while empty");
`endif

endmodule

// ----- src/hdrc_back.sv -----
module hdrc_back #(
	parameter int DEPTH_LOG2   = 12,
	parameter int PAYLOAD_BITS = 32,
	parameter int EPOCH_BITS   = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   q_valid,
	input  hdrc_pkg::op_t                          q_op,
	input  logic [DEPTH_LOG2-1:0]                  q_idx,
	output hdrc_pkg::back_stat_t                   stat,
	output logic                                   done,
	output logic                                   hit,
	output logic                                   status_out,
	output logic [hdrc_pkg::PORT_PAYLOAD_BITS-1:0] payload_out,
	output logic [hdrc_pkg::CNT_BITS-1:0]          insertions,
	output logic [hdrc_pkg::CNT_BITS-1:0]          collisions
);
	import hdrc_pkg::*;

	localparam int DEPTH = 1 << DEPTH_LOG2;
	localparam int PW = (PAYLOAD_BITS < PORT_PAYLOAD_BITS) ? PAYLOAD_BITS : PORT_PAYLOAD_BITS;
	localparam int DW = BOARD_BITS + KEY_BITS + 1 + PW;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t                  state_q;
	logic [DEPTH_LOG2-1:0]   clr_idx_q, idx_q;
	logic [EPOCH_BITS-1:0]   epoch_q;
	logic [CNT_BITS-1:0]     ins_q, col_q;
	op_t                     op_q;

	logic [EPOCH_BITS-1:0]   tag_mem [DEPTH];
	logic [DW-1:0]           data_mem [DEPTH];
	logic [EPOCH_BITS-1:0]   tag_rd_q;
	logic [DW-1:0]           data_rd_q;

	logic                    done_q, hit_q, st_q;
	logic [PW-1:0]           pl_q;

	logic                    pop, live, same, cacheable, do_ins, lookup_hit;
	logic                    tag_we;
	logic [DEPTH_LOG2-1:0]   tag_wa;
	logic [EPOCH_BITS-1:0]   tag_wd;
	logic [DW-1:0]           wdata;
	logic [BOARD_BITS-1:0]   rd_board;
	logic [KEY_BITS-1:0]     rd_key;

	assign pop       = (state_q == ST_IDLE) && q_valid;
	assign rd_board  = data_rd_q[DW-1 -: BOARD_BITS];
	assign rd_key    = data_rd_q[DW-1-BOARD_BITS -: KEY_BITS];
	assign live      = (tag_rd_q == epoch_q);
	assign same      = (rd_board == op_q.board) && (rd_key == op_q.key);
	assign cacheable = (op_q.status <= STATUS_IMPOSSIBLE);
	assign do_ins    = (state_q == ST_EXEC) && (op_q.func == FUNC_INSERT) && cacheable;
	assign lookup_hit = (op_q.func == FUNC_LOOKUP) && live && same;

	// The clearing sweep and inserts share the tag write port.
	assign tag_we = (state_q == ST_CLEAR) || do_ins;
	assign tag_wa = (state_q == ST_CLEAR) ? clr_idx_q : idx_q;
	assign tag_wd = (state_q == ST_CLEAR) ? '0 : epoch_q;
	assign wdata  = {op_q.board, op_q.key, op_q.status[0], op_q.payload[PW-1:0]};

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_wa] <= tag_wd;
		end
		if (do_ins) begin
			data_mem[idx_q] <= wdata;
		end
		if (pop) begin
			tag_rd_q  <= tag_mem[q_idx];
			data_rd_q <= data_mem[q_idx];
			op_q      <= q_op;
			idx_q     <= q_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
			epoch_q   <= EPOCH_BITS'(1);
			ins_q     <= '0;
			col_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= (state_q == ST_EXEC);
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + DEPTH_LOG2'(1);
					if (&clr_idx_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// An invalidate that wraps the epoch sends the back end into a tag sweep.
					if ((op_q.func == FUNC_INVALIDATE) && (&epoch_q)) begin
						state_q <= ST_CLEAR;
					end else begin
						state_q <= ST_IDLE;
					end
					unique case (op_q.func)
						FUNC_LOOKUP: begin
						end
						FUNC_INSERT: begin
							if (cacheable) begin
								ins_q <= ins_q + CNT_BITS'(1);
								if (live && !same) begin
									col_q <= col_q + CNT_BITS'(1);
								end
							end
						end
						FUNC_INVALIDATE: begin
							ins_q <= '0;
							col_q <= '0;
							// On wrap every tag must go back to zero before reuse.
							if (&epoch_q) begin
								epoch_q   <= EPOCH_BITS'(1);
								clr_idx_q <= '0;
							end else begin
								epoch_q <= epoch_q + EPOCH_BITS'(1);
							end
						end
						FUNC_CLEAR_COUNTS: begin
							ins_q <= '0;
							col_q <= '0;
						end
						default: begin
						end
					endcase
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		hit_q <= lookup_hit;
		st_q  <= lookup_hit & data_rd_q[PW];
		pl_q  <= lookup_hit ? data_rd_q[PW-1:0] : '0;
	end

	assign stat.pop      = pop;
	assign stat.clearing = (state_q == ST_CLEAR);
	assign done          = done_q;
	assign hit           = hit_q;
	assign status_out    = st_q;
	assign payload_out   = PORT_PAYLOAD_BITS'(pl_q);
	assign insertions    = ins_q;
	assign collisions    = col_q;

`ifndef SYNTHESIS
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_EXEC))
		else $error("result strobe without an executed item");
	a_epoch_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != '0)
		else $error("epoch reached zero");
`endif

endmodule

// ----- src/hashed_direct_mapped_result_cache_core.sv -----
// Channel    | Ports                                        | Handshake
// -----------+----------------------------------------------+---------------------------------
// config     | cfg_we, cfg_wdata                            | written on any edge with cfg_we
// item in    | start, busy, func, occupancy, piece, ...     | taken on an edge with start & !busy
// result out | done, hit, status_out, payload_out, counters | valid for the one cycle of done
//
// An item passes through the hash pipeline and the queue and then the back end: first the
// synchronous entry read, then the compare, update and result register. The back end
// finishes one item before it takes the next one from the queue.
// After reset, and after an invalidate that wraps the epoch, busy stays high while
// the whole tag memory is swept to zero, one entry per cycle.
// busy also rises when eight items are between acceptance and the back end; the receiver
// cannot stall, and each result appears for exactly one cycle.
module hashed_direct_mapped_result_cache_core #(
	parameter int DEPTH_LOG2   = 12,
	parameter int PAYLOAD_BITS = 32,
	parameter int EPOCH_BITS   = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [hdrc_pkg::CFG_BITS-1:0]          cfg_wdata,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [1:0]                             func,
	input  logic [63:0]                            occupancy,
	input  logic [7:0]                             piece,
	input  logic [7:0]                             rotation,
	input  logic signed [7:0]                      column,
	input  logic signed [7:0]                      adjusted_row,
	input  logic [7:0]                             search_mode,
	input  logic [7:0]                             trace_setting,
	input  logic [1:0]                             status_in,
	input  logic [31:0]                            payload_in,
	output logic                                   done,
	output logic                                   hit,
	output logic                                   status_out,
	output logic [31:0]                            payload_out,
	output logic [31:0]                            insertions,
	output logic [31:0]                            collisions
);
	import hdrc_pkg::*;

	localparam int QW = $bits(op_t) + DEPTH_LOG2;

	logic [CFG_BITS-1:0]   idx_bits_q;
	logic [QCNT_BITS-1:0]  inflight_q;
	logic                  accept;
	op_t                   in_op, hash_op, head_op;
	logic                  hash_valid, q_not_empty;
	logic [DEPTH_LOG2-1:0] hash_idx, head_idx;
	logic [QW-1:0]         head_data;
	back_stat_t            stat;

	// The configuration register only matters once the hash reaches its last stage,
	// and the user must make writes only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_bits_q <= INDEX_BITS_RESET;
		end else if (cfg_we) begin
			idx_bits_q <= cfg_wdata;
		end
	end

	assign accept = start && !busy;

	// Key bytes are packed lowest first; signed bytes keep their raw bits.
	always_comb begin
		in_op.func    = func_t'(func);
		in_op.board   = occupancy;
		in_op.key     = {trace_setting, search_mode, adjusted_row, column, rotation, piece};
		in_op.status  = status_in;
		in_op.payload = payload_in;
	end

	// Credit count of items accepted but not yet taken by the back end. Holding it at
	// the queue depth guarantees the queue never overflows when the hash delivers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (accept && !stat.pop) begin
			inflight_q <= inflight_q + QCNT_BITS'(1);
		end else if (stat.pop && !accept) begin
			inflight_q <= inflight_q - QCNT_BITS'(1);
		end
	end

	assign busy = stat.clearing || (inflight_q == QCNT_BITS'(QDEPTH));

	hdrc_hash #(
		.DEPTH_LOG2 (DEPTH_LOG2)
	) u_hash (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept),
		.in_op      (in_op),
		.index_bits (idx_bits_q),
		.out_valid  (hash_valid),
		.out_op     (hash_op),
		.out_idx    (hash_idx)
	);

	hdrc_queue #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (hash_valid),
		.push_data ({hash_op, hash_idx}),
		.pop       (stat.pop),
		.not_empty (q_not_empty),
		.head_data (head_data)
	);

	assign head_op  = op_t'(head_data[QW-1 -: $bits(op_t)]);
	assign head_idx = head_data[DEPTH_LOG2-1:0];

	hdrc_back #(
		.DEPTH_LOG2   (DEPTH_LOG2),
		.PAYLOAD_BITS (PAYLOAD_BITS),
		.EPOCH_BITS   (EPOCH_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_not_empty),
		.q_op        (head_op),
		.q_idx       (head_idx),
		.stat        (stat),
		.done        (done),
		.hit         (hit),
		.status_out  (status_out),
		.payload_out (payload_out),
		.insertions  (insertions),
		.collisions  (collisions)
	);

`ifndef SYNTHESIS
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (inflight_q < QCNT_BITS'(QDEPTH)))
		else $error("item accepted beyond queue credit");
`endif

endmodule

// ----- sim/hdrc_scoreboard.sv -----
// Watches all three channels of the cache core, predicts every result from the items
// that it sees accepted, and compares each result with the oldest prediction.
module hdrc_scoreboard #(
	parameter int DEPTH_LOG2 = 12,
	parameter int EPOCH_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [hdrc_pkg::CFG_BITS-1:0] cfg_wdata,
	input  logic                          start,
	input  logic                          busy,
	input  logic [1:0]                    func,
	input  logic [63:0]                   occupancy,
	input  logic [7:0]                    piece,
	input  logic [7:0]                    rotation,
	input  logic [7:0]                    column,
	input  logic [7:0]                    adjusted_row,
	input  logic [7:0]                    search_mode,
	input  logic [7:0]                    trace_setting,
	input  logic [1:0]                    status_in,
	input  logic [31:0]                   payload_in,
	input  logic                          done,
	input  logic                          hit,
	input  logic                          status_out,
	input  logic [31:0]                   payload_out,
	input  logic [31:0]                   insertions,
	input  logic [31:0]                   collisions,
	output int                            mismatch_count,
	output int                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import hdrc_pkg::*;

	localparam int          ENTRIES    = 1 << DEPTH_LOG2;
	localparam logic [31:0] EPOCH_MASK = 32'hFFFF_FFFF >> (32 - EPOCH_BITS);

	typedef struct packed {
		logic        hit;
		logic        status;
		logic [31:0] payload;
		logic [31:0] insertions;
		logic [31:0] collisions;
	} answer_t;

	answer_t answers_due[$];

	logic [31:0]         tag_mem     [ENTRIES];
	logic [63:0]         board_mem   [ENTRIES];
	logic [KEY_BITS-1:0] key_mem     [ENTRIES];
	logic                status_mem  [ENTRIES];
	logic [31:0]         payload_mem [ENTRIES];
	logic [31:0]         epoch;
	logic [31:0]         insert_total;
	logic [31:0]         collision_total;
	logic [CFG_BITS-1:0] index_bits;

	// Finalizer hash, then keep the low bits that the register selects.
	function automatic int unsigned slot_of(logic [63:0] board, logic [KEY_BITS-1:0] key);
		logic [63:0] h;
		int unsigned width;
		h = board ^ ({16'd0, key} + MIX_ADD);
		h = (h ^ (h >> MIX_SH1)) * MIX_MUL1;
		h = (h ^ (h >> MIX_SH2)) * MIX_MUL2;
		h = h ^ (h >> MIX_SH3);
		width = index_bits;
		if (width < MIN_INDEX_BITS) width = MIN_INDEX_BITS;
		if (width > DEPTH_LOG2) width = DEPTH_LOG2;
		return int'(h & ((64'd1 << width) - 64'd1));
	endfunction

	function automatic answer_t cache_step(func_t op, logic [63:0] board,
			logic [KEY_BITS-1:0] key, logic [1:0] st, logic [31:0] pl);
		answer_t a;
		int unsigned s;
		a = '0;
		s = slot_of(board, key);
		case (op)
		FUNC_LOOKUP: begin
			if (tag_mem[s] == epoch && board_mem[s] == board && key_mem[s] == key) begin
				a.hit = 1'b1;
				a.status = status_mem[s];
				a.payload = payload_mem[s];
			end
		end
		FUNC_INSERT: begin
			if (st <= STATUS_IMPOSSIBLE) begin
				insert_total++;
				if (tag_mem[s] == epoch && (board_mem[s] != board || key_mem[s] != key))
					collision_total++;
				board_mem[s] = board;
				key_mem[s] = key;
				status_mem[s] = st[0];
				payload_mem[s] = pl;
				tag_mem[s] = epoch;
			end
		end
		FUNC_INVALIDATE: begin
			epoch = (epoch + 32'd1) & EPOCH_MASK;
			if (epoch == '0) begin
				for (int i = 0; i < ENTRIES; i++) tag_mem[i] = '0;
				epoch = 32'd1;
			end
			insert_total = '0;
			collision_total = '0;
		end
		default: begin
			insert_total = '0;
			collision_total = '0;
		end
		endcase
		a.insertions = insert_total;
		a.collisions = collision_total;
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		answer_t got;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) tag_mem[i] = '0;
			epoch = 32'd1;
			insert_total = '0;
			collision_total = '0;
			index_bits = INDEX_BITS_RESET;
			answers_due.delete();
			mismatch_count = 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				got = '{hit, status_out, payload_out, insertions, collisions};
				if (answers_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: hit %0d status %0d payload %h ins %0d col %0d",
							hit, status_out, payload_out, insertions, collisions);
				end else begin
					want = answers_due.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$write("mismatch (expected/actual): hit %0d/%0d status %0d/%0d",
								want.hit, got.hit, want.status, got.status);
							$display(" payload %h/%h ins %0d/%0d col %0d/%0d",
								want.payload, got.payload, want.insertions, got.insertions,
								want.collisions, got.collisions);
						end
					end
				end
			end
			if (start && !busy)
				answers_due.push_back(cache_step(func_t'(func), occupancy,
					{trace_setting, search_mode, adjusted_row, column, rotation, piece},
					status_in, payload_in));
			if (cfg_we)
				index_bits = cfg_wdata;
			outstanding <= answers_due.size();
		end
	end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the hashed direct-mapped result cache. It makes the stimulus
// and gives the verdict; the scoreboard beside the block does all prediction.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hdrc_pkg::*;

	// A narrow epoch makes the wrap (and its tag sweep) reachable within the run.
	localparam int DEPTH_LOG2 = 12;
	localparam int EPOCH_W    = 3;
	localparam int POOL_SIZE  = 16;

	// The identity of a cached answer: board plus the six key bytes.
	typedef struct packed {
		logic [63:0] board;
		logic [7:0]  piece;
		logic [7:0]  rotation;
		logic [7:0]  column;
		logic [7:0]  adjusted_row;
		logic [7:0]  search_mode;
		logic [7:0]  trace_setting;
	} ident_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFG_BITS-1:0] cfg_wdata = '0;
	logic                start = 1'b0;
	logic                busy;
	logic [1:0]          func = FUNC_LOOKUP;
	logic [63:0]         occupancy = '0;
	logic [7:0]          piece = '0;
	logic [7:0]          rotation = '0;
	logic signed [7:0]   column = '0;
	logic signed [7:0]   adjusted_row = '0;
	logic [7:0]          search_mode = '0;
	logic [7:0]          trace_setting = '0;
	logic [1:0]          status_in = '0;
	logic [31:0]         payload_in = '0;
	logic                done;
	logic                hit;
	logic                status_out;
	logic [31:0]         payload_out;
	logic [31:0]         insertions;
	logic [31:0]         collisions;
	int                  mismatch_count;
	int                  outstanding;

	// Identities that get reused, so that lookups hit and inserts overwrite.
	ident_t pool[POOL_SIZE];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	hashed_direct_mapped_result_cache_core #(
		.DEPTH_LOG2(DEPTH_LOG2),
		.PAYLOAD_BITS(32),
		.EPOCH_BITS(EPOCH_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.func(func),
		.occupancy(occupancy),
		.piece(piece),
		.rotation(rotation),
		.column(column),
		.adjusted_row(adjusted_row),
		.search_mode(search_mode),
		.trace_setting(trace_setting),
		.status_in(status_in),
		.payload_in(payload_in),
		.done(done),
		.hit(hit),
		.status_out(status_out),
		.payload_out(payload_out),
		.insertions(insertions),
		.collisions(collisions)
	);

	hdrc_scoreboard #(
		.DEPTH_LOG2(DEPTH_LOG2),
		.EPOCH_BITS(EPOCH_W)
	) u_scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.func(func),
		.occupancy(occupancy),
		.piece(piece),
		.rotation(rotation),
		.column(column),
		.adjusted_row(adjusted_row),
		.search_mode(search_mode),
		.trace_setting(trace_setting),
		.status_in(status_in),
		.payload_in(payload_in),
		.done(done),
		.hit(hit),
		.status_out(status_out),
		.payload_out(payload_out),
		.insertions(insertions),
		.collisions(collisions),
		.mismatch_count(mismatch_count),
		.outstanding(outstanding)
	);

	// Bytes lean toward the extremes so that sign and boundary bits are exercised often.
	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
		0: return 8'h00;
		1: return 8'hFF;
		2: return 8'h80;
		3: return 8'h7F;
		default: return 8'($urandom());
		endcase
	endfunction

	function automatic ident_t rand_ident();
		ident_t id;
		case ($urandom_range(9))
		0: id.board = '0;
		1: id.board = '1;
		default: id.board = {$urandom(), $urandom()};
		endcase
		id.piece = rand_byte();
		id.rotation = rand_byte();
		id.column = rand_byte();
		id.adjusted_row = rand_byte();
		id.search_mode = rand_byte();
		id.trace_setting = rand_byte();
		return id;
	endfunction

	// Present one item at the current edge and hold it until the block takes it.
	// The task returns at the accepting edge, so a following item can go out at
	// once with no bubble.
	task automatic put_item(input func_t op, input ident_t id, input logic [1:0] st,
			input logic [31:0] pl);
		start <= 1'b1;
		func <= op;
		occupancy <= id.board;
		piece <= id.piece;
		rotation <= id.rotation;
		column <= id.column;
		adjusted_row <= id.adjusted_row;
		search_mode <= id.search_mode;
		trace_setting <= id.trace_setting;
		status_in <= st;
		payload_in <= pl;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Stop sending and wait until every predicted result has come back and any
	// tag sweep is over. The first edge lets the scoreboard count the last item.
	// The trailing cycles cover the pipeline latency.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || busy) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	initial begin : stimulus
		ident_t zero_id;
		ident_t ones_id;
		ident_t mid_id;
		ident_t id;
		func_t op;
		logic [1:0] st;
		int unsigned pick;
		int unsigned burst_left;
		int unsigned cfg_plan[6];
		bit steady;

		cfg_plan = '{8, 15, 0, 12, 10, 9};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, run at the reset value of the index register. The block
		// is still sweeping its tags here, so the first item waits on busy.
		zero_id = '0;
		ones_id = '1;
		mid_id = '{64'h8000_0000_0000_0001, 8'h5A, 8'h01, 8'h80, 8'h7F, 8'hA5, 8'h3C};
		put_item(FUNC_LOOKUP, zero_id, STATUS_OK, 32'h0);          // miss on an empty cache
		put_item(FUNC_INSERT, ones_id, STATUS_OK, 32'hFFFF_FFFF);
		put_item(FUNC_LOOKUP, ones_id, STATUS_OK, 32'h0);          // hit, status ok
		put_item(FUNC_INSERT, zero_id, STATUS_IMPOSSIBLE, 32'h0);
		put_item(FUNC_LOOKUP, zero_id, STATUS_OK, 32'h0);          // hit, status impossible
		// Statuses above impossible must be dropped without counting.
		put_item(FUNC_INSERT, mid_id, 2'd2, 32'h1234_5678);
		put_item(FUNC_INSERT, mid_id, 2'd3, 32'h8765_4321);
		put_item(FUNC_LOOKUP, mid_id, STATUS_OK, 32'h0);
		// Rewriting the same identity replaces the answer but is no collision.
		put_item(FUNC_INSERT, ones_id, STATUS_IMPOSSIBLE, 32'h5A5A_A5A5);
		put_item(FUNC_LOOKUP, ones_id, STATUS_OK, 32'h0);
		put_item(FUNC_CLEAR_COUNTS, zero_id, STATUS_OK, 32'h0);
		put_item(FUNC_LOOKUP, ones_id, STATUS_OK, 32'h0);          // entries survive a count clear
		put_item(FUNC_INVALIDATE, zero_id, STATUS_OK, 32'h0);
		put_item(FUNC_LOOKUP, ones_id, STATUS_OK, 32'h0);          // stale after invalidate
		put_item(FUNC_INSERT, mid_id, STATUS_OK, 32'hCAFE_0001);
		// Seven invalidates walk the narrow epoch once around, through the wrap,
		// back to the same epoch value. Only the tag sweep keeps the old entry dead.
		repeat (7) put_item(FUNC_INVALIDATE, mid_id, STATUS_OK, 32'h0);
		put_item(FUNC_LOOKUP, mid_id, STATUS_OK, 32'h0);
		put_item(FUNC_INSERT, mid_id, STATUS_OK, 32'hCAFE_0002);
		put_item(FUNC_LOOKUP, mid_id, STATUS_OK, 32'h0);

		// Random part: six phases, each with its own index width, including the
		// two ends of the range and values that must saturate from either side.
		burst_left = 0;
		for (int ph = 0; ph < 6; ph++) begin
			settle();
			cfg_wdata <= CFG_BITS'((ph == 5) ? $urandom_range(15) : cfg_plan[ph]);
			cfg_we <= 1'b1;
			@(posedge clk);
			cfg_we <= 1'b0;
			for (int i = 0; i < POOL_SIZE; i++) pool[i] = rand_ident();
			// A width change only takes effect cleanly behind an invalidate.
			put_item(FUNC_INVALIDATE, rand_ident(), 2'($urandom_range(3)), $urandom());
			steady = (ph == 2);
			for (int n = 0; n < 200; n++) begin
				pick = $urandom_range(99);
				id = ($urandom_range(4) != 0) ? pool[$urandom_range(POOL_SIZE - 1)]
					: rand_ident();
				st = ($urandom_range(9) == 0) ? 2'($urandom_range(3, 2))
					: 2'($urandom_range(1));
				if (pick < 45)
					op = FUNC_LOOKUP;
				else if (pick < 88)
					op = FUNC_INSERT;
				else if (pick < 93)
					op = FUNC_INVALIDATE;
				else
					op = FUNC_CLEAR_COUNTS;
				// Fresh identities drift into the pool so that hits keep coming.
				if (op == FUNC_INSERT && $urandom_range(3) == 0)
					pool[$urandom_range(POOL_SIZE - 1)] = id;
				put_item(op, id, st, $urandom());
				// Bursts of back-to-back items with idle gaps in between; one phase
				// runs without any gaps at all.
				if (!steady) begin
					if (burst_left == 0) begin
						start <= 1'b0;
						repeat ($urandom_range(8, 1)) @(posedge clk);
						burst_left = $urandom_range(24, 1);
					end else begin
						burst_left--;
					end
				end
			end
		end

		settle();
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Hard stop far beyond the slowest legal run, tag sweeps included.
	initial begin : watchdog
		#8_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
